// ----- design/fvcc_pkg.sv -----
// Shared types, constants and the arctangent table for the flow color coder.
// No dependencies; the top level, the stage and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package fvcc_pkg;

  // Default hue segment lengths of the color wheel
  localparam int RED_YELLOW_STEPS_DEF   = 15;
  localparam int YELLOW_GREEN_STEPS_DEF = 6;
  localparam int GREEN_CYAN_STEPS_DEF   = 4;
  localparam int CYAN_BLUE_STEPS_DEF    = 11;
  localparam int BLUE_MAGENTA_STEPS_DEF = 13;
  localparam int MAGENTA_RED_STEPS_DEF  = 6;

  // Vectoring iterations, iterations per pipeline stage and stage count
  localparam int CORDIC_STEPS  = 28;
  localparam int STEPS_PER_STG = 2;
  localparam int NUM_STG       = CORDIC_STEPS / STEPS_PER_STG;

  // Bit pairs of the squared radius resolved by the square root
  localparam int SQRT_STEPS = 16;

  // CORDIC datapath width; operands reach about 2^30.2
  localparam int CW = 34;

  localparam logic [32:0] QUARTER_TURN = 33'h0_4000_0000;

  // Arctangent of 2^-i in binary turns, 2^32 = one full turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // Data carried through the angle and radius stages
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [31:0]          r2;
    logic [19:0]          rem;
    logic [15:0]          root;
    logic                 neg_x;
    logic                 neg_y;
    logic                 zero_x;
    logic                 zero_y;
  } stage_t;

endpackage

`default_nettype wire

// ----- design/fvcc_if.sv -----
// Valid/ready channel interfaces for flow vectors in and RGB pixels out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fvcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] flow_x;
  logic signed [15:0] flow_y;
  modport source (output valid, output flow_x, output flow_y, input ready);
  modport sink   (input valid, input flow_x, input flow_y, output ready);
endinterface

interface fvcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- design/flow_vector_color_code.sv -----
// Top level of the optical-flow color coder: input register, vectoring and
// square-root pipeline (fvcc_stage), wheel lookup, blend and output stages.
// Depends on fvcc_pkg, fvcc_if and fvcc_stage.
//
// Usage:
//   in_flow  : valid/ready channel of flow vectors (flow_x, flow_y, Q3.12).
//   out_pix  : valid/ready channel of RGB pixels (red, green, blue).
//   A transfer on in_flow yields exactly one transfer on out_pix, in order.
//   Path from input transfer to the result showing valid:
//   one input register, one register for magnitudes and squared radius,
//   14 vectoring stages of two iterations each (the square root runs in the
//   first eight of them), then angle fold, wheel position multiply, blend,
//   saturation multiply and output register.
//   Throughput is one vector per cycle while out_pix does not stall; every stage is fully pipelined.
//   When out_pix stalls the whole pipeline holds and in_flow.ready drops;
//   nothing is lost or repeated. Bubbles keep moving while the output slot
//   is empty. Synchronous reset clears all valid bits; the block keeps no
//   other state and needs no setup.
`timescale 1ns / 1ps
`default_nettype none

module flow_vector_color_code
  import fvcc_pkg::*;
#(
  parameter int RED_YELLOW_STEPS   = RED_YELLOW_STEPS_DEF,
  parameter int YELLOW_GREEN_STEPS = YELLOW_GREEN_STEPS_DEF,
  parameter int GREEN_CYAN_STEPS   = GREEN_CYAN_STEPS_DEF,
  parameter int CYAN_BLUE_STEPS    = CYAN_BLUE_STEPS_DEF,
  parameter int BLUE_MAGENTA_STEPS = BLUE_MAGENTA_STEPS_DEF,
  parameter int MAGENTA_RED_STEPS  = MAGENTA_RED_STEPS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fvcc_in_if.sink   in_flow,
  fvcc_out_if.source out_pix
);

  localparam int NCOLS = RED_YELLOW_STEPS + YELLOW_GREEN_STEPS + GREEN_CYAN_STEPS +
                         CYAN_BLUE_STEPS + BLUE_MAGENTA_STEPS + MAGENTA_RED_STEPS;
  localparam int IDX_W = $clog2(NCOLS);
  localparam int SEG1  = RED_YELLOW_STEPS;
  localparam int SEG2  = SEG1 + YELLOW_GREEN_STEPS;
  localparam int SEG3  = SEG2 + GREEN_CYAN_STEPS;
  localparam int SEG4  = SEG3 + CYAN_BLUE_STEPS;
  localparam int SEG5  = SEG4 + BLUE_MAGENTA_STEPS;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NCOLS - 1);
  localparam logic [IDX_W-1:0] WHEEL_MUL = IDX_W'(NCOLS - 1);

  // Color wheel table, red in the top byte
  logic [23:0] wheel_rom [NCOLS];

  for (genvar k = 0; k < NCOLS; k++) begin : g_wheel
    localparam int RV = (k < SEG1) ? 255 :
                        (k < SEG2) ? 255 - (255 * (k - SEG1)) / YELLOW_GREEN_STEPS :
                        (k < SEG4) ? 0 :
                        (k < SEG5) ? (255 * (k - SEG4)) / BLUE_MAGENTA_STEPS : 255;
    localparam int GV = (k < SEG1) ? (255 * k) / RED_YELLOW_STEPS :
                        (k < SEG3) ? 255 :
                        (k < SEG4) ? 255 - (255 * (k - SEG3)) / CYAN_BLUE_STEPS : 0;
    localparam int BV = (k < SEG2) ? 0 :
                        (k < SEG3) ? (255 * (k - SEG2)) / GREEN_CYAN_STEPS :
                        (k < SEG5) ? 255 :
                        255 - (255 * (k - SEG5)) / MAGENTA_RED_STEPS;
    assign wheel_rom[k] = {8'(RV), 8'(GV), 8'(BV)};
  end

  // Global advance: move when the output slot is free or being taken
  logic en;
  logic out_vld_r;

  assign en            = !out_vld_r || out_pix.ready;
  assign in_flow.ready = en;

  // Input register
  logic               p0_vld_r;
  logic signed [15:0] p0_x_r;
  logic signed [15:0] p0_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= in_flow.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_x_r <= in_flow.flow_x;
      p0_y_r <= in_flow.flow_y;
    end
  end

  // Magnitudes, squared radius and vectoring start values
  logic signed [16:0] xe;
  logic signed [16:0] ye;
  logic [16:0]        ax;
  logic [16:0]        ay;
  logic [33:0]        r2_full;
  stage_t             init;
  logic               p1_vld_r;
  stage_t             p1_dat_r;

  always_comb begin
    xe          = {p0_x_r[15], p0_x_r};
    ye          = {p0_y_r[15], p0_y_r};
    ax          = xe[16] ? 17'(-xe) : 17'(xe);
    ay          = ye[16] ? 17'(-ye) : 17'(ye);
    r2_full     = 34'(ax * ax) + 34'(ay * ay);
    init        = '0;
    init.cx     = $signed(CW'({ax, 14'b0}));
    init.cy     = $signed(CW'({ay, 14'b0}));
    init.r2     = r2_full[31:0];
    init.neg_x  = xe[16];
    init.neg_y  = ye[16];
    init.zero_x = (ax == 17'd0);
    init.zero_y = (ay == 17'd0);
  end

  // Hold the start values in their own stage ahead of the vectoring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dat_r <= init;
    end
  end

  // Vectoring and square-root pipeline
  logic   stg_vld [NUM_STG+1];
  stage_t stg_dat [NUM_STG+1];

  assign stg_vld[0] = p1_vld_r;
  assign stg_dat[0] = p1_dat_r;

  for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
    fvcc_stage #(.STAGE(s)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (stg_vld[s]),
      .d     (stg_dat[s]),
      .vld_o (stg_vld[s+1]),
      .q     (stg_dat[s+1])
    );
  end

  // Fold the first-quadrant angle into the full turn
  stage_t      last;
  logic [30:0] quad;
  logic [32:0] full;
  logic        f1_vld_r;
  logic [31:0] f1_ang_r;
  logic [15:0] f1_rad_r;
  logic        f1_small_r;

  assign last = stg_dat[NUM_STG];

  always_comb begin
    priority if (last.zero_y) begin
      quad = '0;
    end else if (last.zero_x) begin
      quad = QUARTER_TURN[30:0];
    end else if (last.cz < 0) begin
      quad = '0;
    end else if (last.cz > $signed(CW'(QUARTER_TURN))) begin
      quad = QUARTER_TURN[30:0];
    end else begin
      quad = last.cz[30:0];
    end
    unique case ({last.neg_x, last.neg_y})
      2'b00:   full = {2'b00, quad};
      2'b10:   full = (QUARTER_TURN << 1) - {2'b00, quad};
      2'b11:   full = (QUARTER_TURN << 1) + {2'b00, quad};
      default: full = (QUARTER_TURN << 2) - {2'b00, quad};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= stg_vld[NUM_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ang_r   <= full[31:0];
      f1_rad_r   <= last.root;
      f1_small_r <= (last.r2 <= 32'h0100_0000);
    end
  end

  // Wheel position: index and 8-bit blend fraction
  logic [31+IDX_W:0] pos_prod;
  logic [IDX_W-1:0]  k0_raw;
  logic              f2_vld_r;
  logic [IDX_W-1:0]  f2_k0_r;
  logic [7:0]        f2_frac_r;
  logic [15:0]       f2_rad_r;
  logic              f2_small_r;

  assign pos_prod = f1_ang_r * WHEEL_MUL;
  assign k0_raw   = pos_prod[31+IDX_W:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_k0_r    <= (k0_raw > LAST_IDX) ? LAST_IDX : k0_raw;
      f2_frac_r  <= pos_prod[31:24];
      f2_rad_r   <= f1_rad_r;
      f2_small_r <= f1_small_r;
    end
  end

  // Blend the two neighboring wheel entries
  logic [IDX_W-1:0] k1;
  logic [23:0]      c0;
  logic [23:0]      c1;
  logic [8:0]       wa;
  logic [15:0]      blend [3];
  logic             f3_vld_r;
  logic [15:0]      f3_b_r [3];
  logic [15:0]      f3_rad_r;
  logic             f3_small_r;

  always_comb begin
    k1 = (f2_k0_r == LAST_IDX) ? '0 : f2_k0_r + 1'b1;
    c0 = wheel_rom[f2_k0_r];
    c1 = wheel_rom[k1];
    wa = 9'd256 - {1'b0, f2_frac_r};
    for (int c = 0; c < 3; c++) begin
      blend[c] = 16'(17'(wa * c0[23-8*c -: 8]) + 17'(f2_frac_r * c1[23-8*c -: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else if (en) begin
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_b_r     <= blend;
      f3_rad_r   <= f2_rad_r;
      f3_small_r <= f2_small_r;
    end
  end

  // Saturation product inside the unit circle
  logic [31:0] sat [3];
  logic        f4_vld_r;
  logic [31:0] f4_z_r [3];
  logic [15:0] f4_b_r [3];
  logic        f4_small_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c] = f3_rad_r * (16'd65280 - f3_b_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f4_vld_r <= 1'b0;
    end else if (en) begin
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_z_r     <= sat;
      f4_b_r     <= f3_b_r;
      f4_small_r <= f3_small_r;
    end
  end

  // Final channel values: desaturate or dim, then the output register
  logic [32:0] drop_sum [3];
  logic [12:0] drop     [3];
  logic [17:0] dim      [3];
  logic [7:0]  chan     [3];
  logic [7:0]  out_chan_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      drop_sum[c] = {1'b0, f4_z_r[c]} + 33'h0_000F_FFFF;
      drop[c]     = drop_sum[c][32:20];
      dim[c]      = 18'(f4_b_r[c] * 2'd3);
      if (f4_small_r) begin
        chan[c] = (drop[c] >= 13'd255) ? 8'd0 : 8'(13'd255 - drop[c]);
      end else begin
        chan[c] = dim[c][17:10];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= f4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_chan_r <= chan;
    end
  end

  assign out_pix.valid = out_vld_r;
  assign out_pix.red   = out_chan_r[0];
  assign out_pix.green = out_chan_r[1];
  assign out_pix.blue  = out_chan_r[2];

endmodule

`default_nettype wire

// ----- design/fvcc_stage.sv -----
// One pipeline stage: two CORDIC vectoring iterations and, in the early
// stages, two digits of the radius square root. Depends on fvcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fvcc_stage
  import fvcc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   vld_i,
  input  wire stage_t d,
  output logic        vld_o,
  output stage_t      q
);

  function automatic stage_t cordic_step(input stage_t s, input int it);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    stage_t o;
    o  = s;
    dx = s.cy >>> it;
    dy = s.cx >>> it;
    at = $signed({{(CW-32){1'b0}}, ATAN_TURNS[it]});
    if (s.cy > 0) begin
      o.cx = s.cx + dx;
      o.cy = s.cy - dy;
      o.cz = s.cz + at;
    end else begin
      o.cx = s.cx - dx;
      o.cy = s.cy + dy;
      o.cz = s.cz - at;
    end
    return o;
  endfunction

  // Restoring square root digit: bring down one bit pair of r2
  function automatic stage_t sqrt_step(input stage_t s, input int p);
    logic [19:0] sh;
    logic [19:0] t;
    stage_t o;
    o  = s;
    sh = {s.rem[17:0], s.r2[2*p +: 2]};
    t  = {2'b00, s.root, 2'b01};
    if (sh >= t) begin
      o.rem  = sh - t;
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = sh;
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  stage_t s [STEPS_PER_STG+1];

  assign s[0] = d;

  for (genvar k = 0; k < STEPS_PER_STG; k++) begin : g_step
    localparam int IT = STEPS_PER_STG * STAGE + k;
    if (IT < SQRT_STEPS) begin : g_sq
      assign s[k+1] = sqrt_step(cordic_step(s[k], IT), SQRT_STEPS - 1 - IT);
    end else begin : g_nosq
      assign s[k+1] = cordic_step(s[k], IT);
    end
  end

  // Advance on enable; hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= s[STEPS_PER_STG];
    end
  end

endmodule

`default_nettype wire

// ----- test/flow_vector_color_code_test.sv -----
// Testbench for the flow color coder: predicts each RGB pixel from the flow vector
// with a bit-exact integer model and checks every output transfer in order.
// Depends on fvcc_pkg, fvcc_if and flow_vector_color_code.
`timescale 1ns / 1ps

module flow_vector_color_code_test;
  import fvcc_pkg::*;

  localparam int NCOLS = RED_YELLOW_STEPS_DEF + YELLOW_GREEN_STEPS_DEF + GREEN_CYAN_STEPS_DEF
                       + CYAN_BLUE_STEPS_DEF + BLUE_MAGENTA_STEPS_DEF + MAGENTA_RED_STEPS_DEF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk;
  logic rst_n;
  fvcc_in_if  in_flow();
  fvcc_out_if out_pix();

  flow_vector_color_code dut (.clk(clk), .rst_n(rst_n), .in_flow(in_flow), .out_pix(out_pix));

  pixel_t pixel_q[$];
  int     mismatches;
  int     pixels_seen;
  int     vectors_sent;
  int     stall_mode;   // 0 random stalls, 1 always ready, 2 long hold-off
  int     hold_cycles;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Segment ramp of the wheel, truncated
  function automatic int ramp(int i, int len);
    return (255 * i) / len;
  endfunction

  function automatic int wheel_comp(int k, int c);
    int v0, v1, v2, i;
    i = k; v0 = 0; v1 = 0; v2 = 0;
    if (i < RED_YELLOW_STEPS_DEF) begin
      v0 = 255; v1 = ramp(i, RED_YELLOW_STEPS_DEF);
    end else if ((i -= RED_YELLOW_STEPS_DEF) < YELLOW_GREEN_STEPS_DEF) begin
      v0 = 255 - ramp(i, YELLOW_GREEN_STEPS_DEF); v1 = 255;
    end else if ((i -= YELLOW_GREEN_STEPS_DEF) < GREEN_CYAN_STEPS_DEF) begin
      v1 = 255; v2 = ramp(i, GREEN_CYAN_STEPS_DEF);
    end else if ((i -= GREEN_CYAN_STEPS_DEF) < CYAN_BLUE_STEPS_DEF) begin
      v1 = 255 - ramp(i, CYAN_BLUE_STEPS_DEF); v2 = 255;
    end else if ((i -= CYAN_BLUE_STEPS_DEF) < BLUE_MAGENTA_STEPS_DEF) begin
      v0 = ramp(i, BLUE_MAGENTA_STEPS_DEF); v2 = 255;
    end else if ((i -= BLUE_MAGENTA_STEPS_DEF) < MAGENTA_RED_STEPS_DEF) begin
      v0 = 255; v2 = 255 - ramp(i, MAGENTA_RED_STEPS_DEF);
    end
    return (c == 0) ? v0 : (c == 1) ? v1 : v2;
  endfunction

  // First-quadrant binary angle by vectoring; >>> on longint floors
  function automatic longint first_quadrant_angle(longint ax, longint ay);
    longint x, y, z, dx, dy;
    z = 0;
    if (ay == 0) return 0;
    if (ax == 0) return longint'(QUARTER_TURN);
    x = ax * 16384; y = ay * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(QUARTER_TURN)) z = longint'(QUARTER_TURN);
    return z;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0; b = 64'd1 << 32;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic pixel_t color_code(logic signed [15:0] fx, logic signed [15:0] fy);
    longint x, y, ax, ay, t, a, pos, r2, rad, z, drop;
    int k0, k1, f, b, v[3];
    pixel_t p;
    x = fx; y = fy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    t = first_quadrant_angle(ax, ay);
    if (x >= 0 && y >= 0) a = t;
    else if (x < 0 && y >= 0) a = 2 * longint'(QUARTER_TURN) - t;
    else if (x < 0) a = 2 * longint'(QUARTER_TURN) + t;
    else a = 4 * longint'(QUARTER_TURN) - t;
    a &= 64'hFFFF_FFFF;
    pos = (a * (NCOLS - 1)) >> 24;
    k0 = int'(pos >> 8);
    f = int'(pos & 255);
    if (k0 >= NCOLS) k0 = NCOLS - 1;
    k1 = (k0 + 1) % NCOLS;
    r2 = ax * ax + ay * ay;
    rad = int_sqrt(r2);
    for (int c = 0; c < 3; c++) begin
      b = (256 - f) * wheel_comp(k0, c) + f * wheel_comp(k1, c);
      if (r2 <= (64'd1 << 24)) begin
        z = rad * (65280 - b);
        drop = (z + ((64'd1 << 20) - 1)) >> 20;
        v[c] = drop >= 255 ? 0 : int'(255 - drop);
      end else v[c] = (3 * b) >> 10;
    end
    p.red = v[0][7:0]; p.green = v[1][7:0]; p.blue = v[2][7:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch on pixel %0d: %s got %0d expected %0d", pixels_seen, what, got, want);
  endtask

  // Send one vector; the prediction is queued at the transfer edge
  task automatic send_vector(logic signed [15:0] fx, logic signed [15:0] fy);
    in_flow.valid  <= 1'b1;
    in_flow.flow_x <= fx;
    in_flow.flow_y <= fy;
    do @(posedge clk); while (!in_flow.ready);
    pixel_q.push_back(color_code(fx, fy));
    vectors_sent++;
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_flow.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = pixel_q.pop_front();
        if (out_pix.red   !== want.red)   report_mismatch("red", out_pix.red, want.red);
        if (out_pix.green !== want.green) report_mismatch("green", out_pix.green, want.green);
        if (out_pix.blue  !== want.blue)  report_mismatch("blue", out_pix.blue, want.blue);
      end
      pixels_seen++;
    end
  end

  // Receiver ready pattern, with a counted hold-off when asked
  always @(negedge clk) begin
    if (stall_mode == 2) begin
      out_pix.ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles--;
      else stall_mode = 0;
    end else if (stall_mode == 1) out_pix.ready <= 1'b1;
    else out_pix.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_directed();
    logic signed [15:0] xs[7];
    xs = '{16'sh0000, 16'sh1000, -16'sh1000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001};
    // zero vector, axes, unit circle, extremes of both fields
    foreach (xs[i]) begin
      send_vector(xs[i], 16'sh0000);
      send_vector(16'sh0000, xs[i]);
    end
    send_vector(-16'sh8000, -16'sh8000);
    send_vector(16'sh7FFF, 16'sh7FFF);
    send_vector(16'sh7FFF, -16'sh8000);
    send_vector(16'sh0B50, 16'sh0B50);
    send_vector(16'sh0B51, -16'sh0B51);
    send_vector(-16'sh0800, 16'sh0DDB);
  endtask

  task automatic test_random(int n);
    int sent, burst;
    logic signed [15:0] fx, fy;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n; i++) begin
        case ($urandom_range(0, 3))
          0: begin fx = $urandom; fy = $urandom; end
          // near and inside unit radius, where saturation varies
          1: begin
            fx = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            fy = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
          end
          2: begin
            fx = $signed(16'($urandom_range(0, 600))) - 16'sd300;
            fy = $signed(16'($urandom_range(0, 600))) - 16'sd300;
          end
          default: begin
            fx = $urandom_range(0, 1) ? 16'sh0000 : 16'($urandom);
            fy = (fx == 0) ? 16'($urandom) : 16'sh0000;
          end
        endcase
        send_vector(fx, fy);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    in_flow.valid <= 1'b0;
  endtask

  task automatic test_backpressure();
    stall_mode = 2;
    hold_cycles = 60;
    for (int i = 0; i < 80; i++) send_vector(16'($urandom), 16'($urandom));
    in_flow.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    in_flow.valid = 1'b0;
    in_flow.flow_x = '0;
    in_flow.flow_y = '0;
    out_pix.ready = 1'b0;
    mismatches = 0; pixels_seen = 0; vectors_sent = 0;
    stall_mode = 0; hold_cycles = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(700);
    stall_mode = 1;
    test_random(700);
    stall_mode = 0;
    test_backpressure();
    drain();
    $display("sent %0d flow vectors (extremes, axes, unit circle, random), checked %0d pixels",
             vectors_sent, pixels_seen);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Safety net well past the slowest correct run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
design/fvcc_pkg.sv
design/fvcc_if.sv
design/fvcc_stage.sv
design/flow_vector_color_code.sv
test/flow_vector_color_code_test.sv
